### sv/rotator_command_position_control_assert.svh
// Assertion macros shared by the checker of the rotator command/position block.
// No dependencies.
`ifndef ROTATOR_COMMAND_POSITION_CONTROL_ASSERT_SVH
`define ROTATOR_COMMAND_POSITION_CONTROL_ASSERT_SVH
// implication checked every clock, off during reset
`define RCPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rcpc assertion failed");
// next-cycle implication
`define RCPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rcpc assertion failed");
`endif

### sv/rcpc_pkg.sv
// Package for the rotator command/position block: sizes, codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rcpc_pkg;
	localparam int AVERAGE_DEPTH_DEF = 128;
	localparam int LINE_CAPACITY_DEF = 32;
	localparam int KEPT_CHARS = 8;
	localparam int REPLY_MAX = 12;
	localparam logic [8:0] AZ_LIMIT_RST = 9'd360;
	localparam logic [8:0] EL_LIMIT_RST = 9'd180;
	localparam logic [0:0] REG_AZ_LIMIT = 1'b0;
	localparam logic [0:0] REG_EL_LIMIT = 1'b1;
	localparam logic [1:0] DRV_OFF = 2'd0;
	localparam logic [1:0] DRV_FWD = 2'd1;
	localparam logic [1:0] DRV_REV = 2'd2;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_QM = 8'h3f;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_GT = 8'h3e;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// command letters
	localparam logic [7:0] KEY_STOP = 8'h53;     // S
	localparam logic [7:0] KEY_POINT = 8'h57;    // W
	localparam logic [7:0] KEY_MOVE = 8'h4d;     // M
	localparam logic [7:0] KEY_REPORT = 8'h43;   // C
	localparam logic [7:0] KEY_BOTH = 8'h32;     // 2
	localparam logic [7:0] KEY_RIGHT = 8'h52;    // R
	localparam logic [7:0] KEY_LEFT = 8'h4c;     // L
	localparam logic [7:0] KEY_UP = 8'h55;       // U
	localparam logic [7:0] KEY_DOWN = 8'h44;     // D
	localparam logic [7:0] KEY_AZ_STOP = 8'h41;  // A
	localparam logic [7:0] KEY_EL_STOP = 8'h45;  // E
	localparam logic [7:0] KEY_ELEV = 8'h42;     // B

	typedef logic [7:0] char_t;
	typedef char_t [REPLY_MAX-1:0] reply_t;

	// three decimal digits of a 9-bit value, hundreds first
	function automatic logic [23:0] dec3(input logic [8:0] v);
		logic [3:0] h;
		logic [3:0] t;
		logic [8:0] r;
		h = 4'((15'(v) * 15'd41) >> 12);
		r = v - 9'(h) * 9'd100;
		t = 4'((11'(r) * 11'd13) >> 7);
		if (r < 9'(t) * 9'd10) t = t - 4'd1;
		r = r - 9'(t) * 9'd10;
		return {8'h30 + 8'(h), 8'h30 + 8'(t), 8'h30 + 8'(r)};
	endfunction
endpackage
`default_nettype wire

### sv/rcpc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rcpc_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 128
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### sv/rcpc_avg.sv
// Moving averages of azimuth and elevation over two ring RAMs.
// Uses rcpc_pkg and rcpc_ram. Clears the rings by a sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module rcpc_avg #(
	parameter int AVERAGE_DEPTH = 128
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	input  wire  [8:0] az_in,
	input  wire  [8:0] el_in,
	output logic       busy,
	output logic       done,
	output logic [8:0] az_avg,
	output logic [8:0] el_avg
);
	import rcpc_pkg::*;
	localparam int AW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
	localparam int SW = AW + 9;
	logic [AW-1:0] pos_q;
	logic [AW:0]   clr_q;
	logic          clearing;
	logic          rd_s1;
	logic [8:0]    az_s1, el_s1, az_old, el_old;
	logic [SW-1:0] az_sum_q, el_sum_q;
	logic [SW-1:0] az_nsum, el_nsum;
	logic          we;
	logic [AW-1:0] waddr;
	logic [8:0]    az_w, el_w;

	assign clearing = clr_q != (AW+1)'(AVERAGE_DEPTH);
	assign busy = clearing || rd_s1;
	assign we = clearing || rd_s1;
	assign waddr = clearing ? clr_q[AW-1:0] : pos_q;
	assign az_w = clearing ? 9'd0 : az_s1;
	assign el_w = clearing ? 9'd0 : el_s1;
	assign az_nsum = az_sum_q - SW'(az_old) + SW'(az_s1);
	assign el_nsum = el_sum_q - SW'(el_old) + SW'(el_s1);

	rcpc_ram #(.WIDTH(9), .DEPTH(AVERAGE_DEPTH)) u_az (
		.clk(clk), .we(we), .waddr(waddr), .wdata(az_w), .raddr(pos_q), .rdata(az_old));
	rcpc_ram #(.WIDTH(9), .DEPTH(AVERAGE_DEPTH)) u_el (
		.clk(clk), .we(we), .waddr(waddr), .wdata(el_w), .raddr(pos_q), .rdata(el_old));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			pos_q <= '0;
			rd_s1 <= 1'b0;
			done <= 1'b0;
			az_sum_q <= '0;
			el_sum_q <= '0;
		end else begin
			done <= 1'b0;
			if (clearing) clr_q <= clr_q + (AW+1)'(1);
			rd_s1 <= start;
			if (rd_s1) begin
				az_sum_q <= az_nsum;
				el_sum_q <= el_nsum;
				pos_q <= (pos_q == AW'(AVERAGE_DEPTH - 1)) ? '0 : pos_q + AW'(1);
				done <= 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			az_s1 <= az_in;
			el_s1 <= el_in;
		end
	end
	assign az_avg = 9'(az_sum_q / AVERAGE_DEPTH);
	assign el_avg = 9'(el_sum_q / AVERAGE_DEPTH);
endmodule
`default_nettype wire

### sv/rotator_command_position_control.sv
// Rotator command/position controller (uses rcpc_pkg, rcpc_avg, rcpc_ram).
// A byte item moves the state register straight to SEND for its first result;
// a sample item passes WAIT first for the ring read, sum update and drive update.
// Replies stream one byte per cycle while out_ready is high, and the next item is
// taken with the final result. After reset the rings are swept to zero, with no
// item accepted.
`timescale 1ns / 1ps
`default_nettype none
module rotator_command_position_control #(
	parameter int AVERAGE_DEPTH = rcpc_pkg::AVERAGE_DEPTH_DEF,
	parameter int LINE_CAPACITY = rcpc_pkg::LINE_CAPACITY_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        func,
	input  wire  [7:0] rx_byte,
	input  wire  [8:0] azimuth_sample,
	input  wire  [8:0] elevation_sample,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [0:0] cfg_index,
	input  wire  [8:0] cfg_data,
	output logic       out_valid,
	input  wire        out_ready,
	output logic       tx_valid,
	output logic [7:0] tx_char,
	output logic       last,
	output logic [1:0] azimuth_drive,
	output logic [1:0] elevation_drive
);
	import rcpc_pkg::*;
	localparam int LW = $clog2(LINE_CAPACITY + 1);
	localparam reply_t REP_DONE = {{10{8'h00}}, CH_LF, CH_CR};
	localparam reply_t REP_ERR = {{9{8'h00}}, CH_GT, CH_SP, CH_QM};

	// Top-level sequencer: IDLE takes an item, WAIT for the ring update, SEND
	// streams reply bytes from a holding register, taking the next item at the end.
	typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_SEND} st_t;
	st_t st_q;

	logic [8:0]  az_lim_q, el_lim_q, az_tgt_q, el_tgt_q, lat_el_q;
	logic        az_act_q, el_act_q;
	logic [1:0]  az_drv_q, el_drv_q;
	logic [LW-1:0] len_q;
	char_t       chars_q [KEPT_CHARS];
	reply_t      rep_q;
	logic [3:0]  rep_len_q, rep_idx_q;
	logic        avg_busy, avg_done;
	logic [8:0]  az_avg, el_avg;
	logic        acc, tick_go;

	// next values from running the pending line
	reply_t      cmd_rep;
	logic [3:0]  cmd_len;
	logic [8:0]  nx_az_tgt, nx_el_tgt;
	logic        nx_az_act, nx_el_act;
	logic [1:0]  nx_az_drv, nx_el_drv;

	assign cfg_ready = 1'b1;
	// take an item while idle or with the last one's final result, never while averaging
	assign in_ready = ((st_q == ST_IDLE) || (st_q == ST_SEND && out_ready && last))
		&& !avg_busy;
	assign acc = in_valid && in_ready;
	assign tick_go = acc && func;

	rcpc_avg #(.AVERAGE_DEPTH(AVERAGE_DEPTH)) u_avg (
		.clk(clk), .arst_n(arst_n), .start(tick_go), .az_in(azimuth_sample),
		.el_in(elevation_sample), .busy(avg_busy), .done(avg_done),
		.az_avg(az_avg), .el_avg(el_avg));

	// Command decode, all combinational on the stored line.
	char_t c0, c1;
	logic [23:0] d_az, d_el, d_lat, d_one;
	assign c0 = chars_q[0];
	assign c1 = chars_q[1];
	assign d_az = dec3(az_avg);
	assign d_el = dec3(el_avg);
	assign d_lat = dec3(lat_el_q);
	assign d_one = (c0 == KEY_REPORT) ? d_az : d_lat;

	// Parse three chars starting at a fixed place; digits up to first zero byte.
	function automatic logic [9:0] parse3(input char_t a, input char_t b, input char_t c,
			input logic [8:0] lim);
		logic [9:0] v;
		logic ok, stop;
		char_t ch [3];
		ch[0] = a; ch[1] = b; ch[2] = c;
		v = '0; ok = 1'b1; stop = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (!stop) begin
				if (ch[k] == 8'd0) stop = 1'b1;
				else if (ch[k] < 8'h30 || ch[k] > 8'h39) begin
					ok = 1'b0; stop = 1'b1;
				end else v = 10'(v * 10'd10 + 10'(ch[k] - 8'h30));
			end
		end
		if (v > 10'(lim)) ok = 1'b0;
		return ok ? {1'b1, v[8:0]} : 10'd0;
	endfunction

	// Line including the terminating zero written at len (if within kept chars).
	char_t ln [KEPT_CHARS];
	always_comb begin
		for (int i = 0; i < KEPT_CHARS; i++)
			ln[i] = (LW'(i) == len_q) ? 8'd0 : chars_q[i];
	end

	logic [9:0] p_az, p_el;
	assign p_az = parse3(ln[1], ln[2], ln[3], az_lim_q);
	assign p_el = parse3(ln[5], ln[6], ln[7], el_lim_q);

	// Run the pending line: reply text and the new targets, flags and drives.
	// Anything unknown or malformed answers "? >".
	always_comb begin
		cmd_rep = REP_ERR;
		cmd_len = 4'd3;
		nx_az_tgt = az_tgt_q; nx_el_tgt = el_tgt_q;
		nx_az_act = az_act_q; nx_el_act = el_act_q;
		nx_az_drv = az_drv_q; nx_el_drv = el_drv_q;
		if (c0 == KEY_STOP && len_q == LW'(1)) begin
			nx_az_drv = DRV_OFF; nx_el_drv = DRV_OFF;
			nx_az_act = 1'b0; nx_el_act = 1'b0;
			cmd_rep = REP_DONE; cmd_len = 4'd2;
		end else if (c0 == KEY_POINT && len_q == LW'(8)) begin
			// a good azimuth sticks even when the elevation field is bad
			if (p_az[9]) nx_az_tgt = p_az[8:0];
			if (p_az[9] && p_el[9]) begin
				nx_el_tgt = p_el[8:0];
				nx_az_act = 1'b1; nx_el_act = 1'b1;
				cmd_rep = REP_DONE; cmd_len = 4'd2;
			end
		end else if (c0 == KEY_MOVE && len_q == LW'(4)) begin
			if (p_az[9]) begin
				nx_az_tgt = p_az[8:0]; nx_az_act = 1'b1;
				cmd_rep = REP_DONE; cmd_len = 4'd2;
			end
		end else if (c0 == KEY_REPORT && len_q >= LW'(2) && c1 == KEY_BOTH) begin
			cmd_rep = {CH_LF, CH_CR, d_el[7:0], d_el[15:8], d_el[23:16],
				CH_ZERO, CH_PLUS, d_az[7:0], d_az[15:8], d_az[23:16],
				CH_ZERO, CH_PLUS};
			cmd_len = 4'd12;
		end else if (len_q == LW'(1) && (c0 == KEY_RIGHT || c0 == KEY_LEFT)) begin
			nx_az_tgt = (c0 == KEY_RIGHT) ? az_lim_q : 9'd0;
			nx_az_act = 1'b1;
			cmd_rep = REP_DONE; cmd_len = 4'd2;
		end else if (len_q == LW'(1) && (c0 == KEY_UP || c0 == KEY_DOWN)) begin
			nx_el_tgt = (c0 == KEY_UP) ? el_lim_q : 9'd0;
			nx_el_act = 1'b1;
			cmd_rep = REP_DONE; cmd_len = 4'd2;
		end else if (len_q == LW'(1) && c0 == KEY_AZ_STOP) begin
			nx_az_drv = DRV_OFF; nx_az_act = 1'b0;
			cmd_rep = REP_DONE; cmd_len = 4'd2;
		end else if (len_q == LW'(1) && c0 == KEY_EL_STOP) begin
			nx_el_drv = DRV_OFF; nx_el_act = 1'b0;
			cmd_rep = REP_DONE; cmd_len = 4'd2;
		end else if (len_q == LW'(1) && (c0 == KEY_REPORT || c0 == KEY_ELEV)) begin
			// one number: azimuth average or latest elevation sample
			cmd_rep = {{5{8'h00}}, CH_LF, CH_CR, d_one[7:0], d_one[15:8], d_one[23:16],
				CH_ZERO, CH_PLUS};
			cmd_len = 4'd7;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !func && rx_byte != CH_CR && len_q < LW'(KEPT_CHARS)
				&& len_q < LW'(LINE_CAPACITY))
			chars_q[len_q[2:0]] <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			az_lim_q <= AZ_LIMIT_RST;
			el_lim_q <= EL_LIMIT_RST;
			az_tgt_q <= '0; el_tgt_q <= '0; lat_el_q <= '0;
			az_act_q <= 1'b0; el_act_q <= 1'b0;
			az_drv_q <= DRV_OFF; el_drv_q <= DRV_OFF;
			len_q <= '0;
			rep_len_q <= '0; rep_idx_q <= '0;
			rep_q <= '0;
		end else begin
			// configuration must arrive only while idle; the block does not enforce it
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_AZ_LIMIT: az_lim_q <= cfg_data;
					REG_EL_LIMIT: el_lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (acc) begin
				// new item: restart the reply stream
				rep_idx_q <= '0;
				if (func) begin
					lat_el_q <= elevation_sample;
					rep_len_q <= '0;
					st_q <= ST_WAIT;
				end else begin
					st_q <= ST_SEND;
					if (rx_byte == CH_CR) begin
						len_q <= '0;
						if (len_q != '0) begin
							rep_q <= cmd_rep;
							rep_len_q <= cmd_len;
							az_tgt_q <= nx_az_tgt; el_tgt_q <= nx_el_tgt;
							az_act_q <= nx_az_act; el_act_q <= nx_el_act;
							az_drv_q <= nx_az_drv; el_drv_q <= nx_el_drv;
						end else begin
							rep_len_q <= '0;  // empty line: no reply
						end
					end else begin
						rep_len_q <= '0;
						if (len_q < LW'(LINE_CAPACITY)) len_q <= len_q + LW'(1);
						else len_q <= '0;  // drop the line on overflow
					end
				end
			end else begin
				unique case (st_q)
					ST_IDLE: ;
					ST_WAIT: begin
						// averages are fresh once the ring update lands
						if (avg_done) begin
							st_q <= ST_SEND;
							if (az_act_q) begin
								if (az_tgt_q > az_avg) az_drv_q <= DRV_FWD;
								else if (az_tgt_q < az_avg) az_drv_q <= DRV_REV;
								else begin az_drv_q <= DRV_OFF; az_act_q <= 1'b0; end
							end
							if (el_act_q) begin
								if (el_tgt_q > el_avg) el_drv_q <= DRV_FWD;
								else if (el_tgt_q < el_avg) el_drv_q <= DRV_REV;
								else begin el_drv_q <= DRV_OFF; el_act_q <= 1'b0; end
							end
						end
					end
					ST_SEND: begin
						// advance one reply byte per accepted result
						if (out_ready) begin
							if (last) st_q <= ST_IDLE;
							else rep_idx_q <= rep_idx_q + 4'd1;
						end
					end
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign out_valid = (st_q == ST_SEND);
	assign tx_valid = rep_len_q != '0;
	assign tx_char = tx_valid ? rep_q[rep_idx_q] : 8'd0;
	assign last = (rep_idx_q + 4'd1 >= rep_len_q);
	assign azimuth_drive = az_drv_q;
	assign elevation_drive = el_drv_q;
endmodule
`default_nettype wire

### sv/rcpc_checker.sv
// Port-level checker for the rotator command/position block, bound to the top.
// Depends on rotator_command_position_control_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rotator_command_position_control_assert.svh"
module rcpc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire       tx_valid,
	input wire [7:0] tx_char,
	input wire       last,
	input wire [1:0] azimuth_drive,
	input wire [1:0] elevation_drive
);
	`RCPC_ASSERT_IMP(a_nochar, clk, arst_n, out_valid && !tx_valid, tx_char == 8'd0 && last)
	`RCPC_ASSERT_IMP(a_azcode, clk, arst_n, 1'b1, azimuth_drive != 2'd3)
	`RCPC_ASSERT_IMP(a_elcode, clk, arst_n, 1'b1, elevation_drive != 2'd3)
	`RCPC_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(tx_char))
endmodule
bind rotator_command_position_control rcpc_checker u_rcpc_checker (.*);
`default_nettype wire

### tb/tb.sv
// Testbench for rotator_command_position_control: directed table, then random
// command lines and sample ticks, checked against a predictor kept in this file.
// Depends on rcpc_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;
	import rcpc_pkg::*;

	localparam int RING_DEPTH = 128;
	localparam int LINE_MAX = 32;
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 400;

	// command letters
	localparam logic [7:0] CMD_STOP = "S";
	localparam logic [7:0] CMD_WHERE = "W";
	localparam logic [7:0] CMD_MOVE = "M";
	localparam logic [7:0] CMD_REPORT = "C";
	localparam logic [7:0] CMD_BOTH = "2";
	localparam logic [7:0] CMD_RIGHT = "R";
	localparam logic [7:0] CMD_LEFT = "L";
	localparam logic [7:0] CMD_UP = "U";
	localparam logic [7:0] CMD_DOWN = "D";
	localparam logic [7:0] CMD_AZ_STOP = "A";
	localparam logic [7:0] CMD_EL_STOP = "E";
	localparam logic [7:0] CMD_ELEV = "B";

	typedef struct packed {
		logic       txv;
		logic [7:0] ch;
		logic       lst;
		logic [1:0] az;
		logic [1:0] el;
	} reply_item_t;

	typedef struct {
		logic       f;
		logic [7:0] b;
		logic [8:0] az;
		logic [8:0] el;
		string      text;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       func;
	logic [7:0] rx_byte;
	logic [8:0] azimuth_sample;
	logic [8:0] elevation_sample;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [0:0] cfg_index;
	logic [8:0] cfg_data;
	logic       out_valid;
	logic       out_ready;
	logic       tx_valid;
	logic [7:0] tx_char;
	logic       last;
	logic [1:0] azimuth_drive;
	logic [1:0] elevation_drive;

	rotator_command_position_control DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .rx_byte(rx_byte),
		.azimuth_sample(azimuth_sample), .elevation_sample(elevation_sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.tx_valid(tx_valid), .tx_char(tx_char), .last(last),
		.azimuth_drive(azimuth_drive), .elevation_drive(elevation_drive)
	);

	// predictor state: a private copy of the block's registers
	logic [7:0] line_chars [8];
	int         line_len;
	logic [8:0] az_ring [RING_DEPTH];
	logic [8:0] el_ring [RING_DEPTH];
	int         ring_idx;
	int unsigned az_total;
	int unsigned el_total;
	int unsigned az_goal;
	int unsigned el_goal;
	bit         az_moving;
	bit         el_moving;
	logic [8:0] last_el;
	logic [1:0] az_motor;
	logic [1:0] el_motor;
	int unsigned az_lim;
	int unsigned el_lim;

	reply_item_t reply_q[$];   // expected result items, oldest first
	string       text_q[$];    // typed-in reply per offered item, "" = unchecked
	int          errors;
	int          items_in;
	int          cycles;
	int          burst_left;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic string fmt_num(int unsigned v);
		return $sformatf("+0%03d", v & 32'h1ff);
	endfunction

	// three-character number field; leaves value untouched when invalid
	function automatic bit read_field(int start, int unsigned lim, inout int unsigned value);
		int unsigned v;
		logic [7:0] c;
		v = 0;
		for (int k = 0; k < 3; k++) begin
			c = line_chars[(start + k) & 7];
			if (c == 8'h00) break;
			if (c < "0" || c > "9") return 1'b0;
			v = v * 10 + (c - "0");
		end
		if (v > lim) return 1'b0;
		value = v;
		return 1'b1;
	endfunction

	function automatic string run_line();
		logic [7:0] c0;
		logic [7:0] c1;
		string s;
		c0 = line_chars[0];
		c1 = line_chars[1];
		s = "";
		if (c0 == CMD_STOP && line_len == 1) begin
			az_motor = DRV_OFF; el_motor = DRV_OFF;
			az_moving = 0; el_moving = 0;
			s = "\r\n";
		end else if (c0 == CMD_WHERE && line_len == 8) begin
			line_chars[4] = 8'h00;
			// azimuth may update even when the elevation field is bad
			if (read_field(1, az_lim, az_goal) && read_field(5, el_lim, el_goal)) begin
				az_moving = 1; el_moving = 1;
				s = "\r\n";
			end else s = "? >";
		end else if (c0 == CMD_MOVE && line_len == 4) begin
			if (read_field(1, az_lim, az_goal)) begin
				az_moving = 1;
				s = "\r\n";
			end else s = "? >";
		end else if (c0 == CMD_REPORT && line_len >= 2 && c1 == CMD_BOTH) begin
			s = {fmt_num(az_total / RING_DEPTH), fmt_num(el_total / RING_DEPTH), "\r\n"};
		end else if (c0 == CMD_RIGHT && line_len == 1) begin
			az_goal = az_lim; az_moving = 1; s = "\r\n";
		end else if (c0 == CMD_LEFT && line_len == 1) begin
			az_goal = 0; az_moving = 1; s = "\r\n";
		end else if (c0 == CMD_UP && line_len == 1) begin
			el_goal = el_lim; el_moving = 1; s = "\r\n";
		end else if (c0 == CMD_DOWN && line_len == 1) begin
			el_goal = 0; el_moving = 1; s = "\r\n";
		end else if (c0 == CMD_AZ_STOP && line_len == 1) begin
			az_motor = DRV_OFF; az_moving = 0; s = "\r\n";
		end else if (c0 == CMD_EL_STOP && line_len == 1) begin
			el_motor = DRV_OFF; el_moving = 0; s = "\r\n";
		end else if (c0 == CMD_REPORT && line_len == 1) begin
			s = {fmt_num(az_total / RING_DEPTH), "\r\n"};
		end else if (c0 == CMD_ELEV && line_len == 1) begin
			s = {fmt_num(last_el), "\r\n"};
		end else s = "? >";
		return s;
	endfunction

	function automatic logic [1:0] steer(int unsigned goal, int unsigned avg, inout bit moving);
		if (goal > avg) return DRV_FWD;
		if (goal < avg) return DRV_REV;
		moving = 0;
		return DRV_OFF;
	endfunction

	// advance the predictor by one accepted item, queue its results
	task automatic predict_item(logic f, logic [7:0] b, logic [8:0] az, logic [8:0] el,
			output string s);
		int n;
		reply_item_t r;
		s = "";
		if (!f) begin
			if (b == CH_CR) begin
				if (line_len > 0) begin
					if (line_len < 8) line_chars[line_len] = 8'h00;
					s = run_line();
				end
				line_len = 0;
			end else if (line_len < LINE_MAX) begin
				if (line_len < 8) line_chars[line_len] = b;
				line_len++;
			end else begin
				line_len = 0;   // overflow: drop the byte and the line
			end
		end else begin
			az_total = az_total - az_ring[ring_idx] + az;
			el_total = el_total - el_ring[ring_idx] + el;
			az_ring[ring_idx] = az;
			el_ring[ring_idx] = el;
			ring_idx = (ring_idx + 1) % RING_DEPTH;
			last_el = el;
			if (az_moving) az_motor = steer(az_goal, az_total / RING_DEPTH, az_moving);
			if (el_moving) el_motor = steer(el_goal, el_total / RING_DEPTH, el_moving);
		end
		n = s.len() > 12 ? 12 : s.len();
		if (n == 0) begin
			r = '{txv: 1'b0, ch: 8'h00, lst: 1'b1, az: az_motor, el: el_motor};
			reply_q.push_back(r);
		end else begin
			for (int k = 0; k < n; k++) begin
				r = '{txv: 1'b1, ch: s[k], lst: (k == n - 1), az: az_motor, el: el_motor};
				reply_q.push_back(r);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Clock, reset, cycle limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout at %0t, %0d results still expected", $time, reply_q.size());
			$display("[rotator_command_position_control] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Monitors: predict on input accept, check on output accept
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		string s;
		string want;
		reply_item_t w;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_AZ_LIMIT) az_lim = cfg_data;
				else az_lim = az_lim;
				if (cfg_index == REG_EL_LIMIT) el_lim = cfg_data;
			end
			if (in_valid && in_ready) begin
				predict_item(func, rx_byte, azimuth_sample, elevation_sample, s);
				want = text_q.pop_front();
				if (want != "" && want != s) begin
					$display("%0t: reply text expected %p, predicted %p", $time, want, s);
					errors++;
				end
				items_in <= items_in + 1;
			end
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					$display("%0t: result expected none, actual %h", $time,
						{tx_valid, tx_char, last, azimuth_drive, elevation_drive});
					errors++;
				end else begin
					w = reply_q.pop_front();
					if (tx_valid !== w.txv) begin
						$display("%0t: tx_valid expected %b actual %b", $time, w.txv, tx_valid);
						errors++;
					end
					if (tx_char !== w.ch) begin
						$display("%0t: tx_char expected %h actual %h", $time, w.ch, tx_char);
						errors++;
					end
					if (last !== w.lst) begin
						$display("%0t: last expected %b actual %b", $time, w.lst, last);
						errors++;
					end
					if (azimuth_drive !== w.az) begin
						$display("%0t: azimuth_drive expected %0d actual %0d", $time,
							w.az, azimuth_drive);
						errors++;
					end
					if (elevation_drive !== w.el) begin
						$display("%0t: elevation_drive expected %0d actual %0d", $time,
							w.el, elevation_drive);
						errors++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: a randomly chosen stall pattern, plus one long
	// hold-off once enough items are in so the block backs up its input
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		int hold;
		int stall_pct;
		bit long_done;
		if (cycles % 64 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end
		if (!long_done && items_in >= 150) begin
			long_done = 1;
			hold = LONG_HOLD;
		end
		if (hold > 0) begin
			hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Sender helpers
	// ------------------------------------------------------------------
	// offer one item; bursts of random length with random gaps between them
	task automatic offer(logic f, logic [7:0] b, logic [8:0] az, logic [8:0] el, string want);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		text_q.push_back(want);
		in_valid <= 1'b1;
		func <= f;
		rx_byte <= b;
		azimuth_sample <= az;
		elevation_sample <= el;
		// ready is stable from the falling edge to the accepting rising edge
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic send_byte(logic [7:0] b);
		offer(1'b0, b, 9'($urandom), 9'($urandom), "");
	endtask

	task automatic send_tick(logic [8:0] az, logic [8:0] el);
		offer(1'b1, 8'($urandom), az, el, "");
	endtask

	function automatic logic [7:0] non_cr();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_CR);
		return b;
	endfunction

	// hold the sender until the block has drained, then let it settle
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (reply_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// three-character number field: mostly digits, sometimes short or corrupt
	task automatic send_field(int unsigned lim);
		int r;
		int unsigned v;
		int keep;
		string d;
		r = $urandom_range(0, 9);
		v = $urandom_range(0, (lim + 20 > 999) ? 999 : lim + 20);
		d = $sformatf("%03d", v);
		if (r < 7) begin
			for (int k = 0; k < 3; k++) send_byte(d[k]);
		end else if (r == 7) begin
			keep = $urandom_range(0, 2);
			for (int k = 0; k < 3; k++) send_byte(k < keep ? d[k] : 8'h00);
		end else begin
			keep = $urandom_range(0, 2);
			for (int k = 0; k < 3; k++) send_byte(k == keep ? non_cr() : d[k]);
		end
	endtask

	// one random command line, or noise
	task automatic send_command();
		int n;
		case ($urandom_range(0, 17))
			0: send_byte(CMD_STOP);
			1, 2: begin
				send_byte(CMD_WHERE);
				send_field(az_lim);
				send_byte(($urandom_range(0, 1)) ? " " : non_cr());
				send_field(el_lim);
			end
			3, 4: begin
				send_byte(CMD_MOVE);
				send_field(az_lim);
			end
			5: begin
				send_byte(CMD_REPORT);
				send_byte(CMD_BOTH);
				n = $urandom_range(0, 3);
				repeat (n) send_byte(non_cr());
			end
			6: send_byte(CMD_RIGHT);
			7: send_byte(CMD_LEFT);
			8: send_byte(CMD_UP);
			9: send_byte(CMD_DOWN);
			10: send_byte(CMD_AZ_STOP);
			11: send_byte(CMD_EL_STOP);
			12: send_byte(CMD_REPORT);
			13: send_byte(CMD_ELEV);
			14: begin
				// noise line of random length
				n = $urandom_range(1, 9);
				repeat (n) send_byte(non_cr());
			end
			15: if ($urandom_range(0, 3) == 0) begin
				// overflow: more than a full line, the extra byte clears it
				n = $urandom_range(LINE_MAX + 1, LINE_MAX + 3);
				repeat (n) send_byte(non_cr());
			end
			16: begin
				// broken line: a command letter with a wrong length
				send_byte(CMD_STOP);
				send_byte(non_cr());
			end
			default: ;   // empty line
		endcase
		send_byte(CH_CR);
	endtask

	task automatic send_ticks();
		int n;
		logic [8:0] az;
		logic [8:0] el;
		n = $urandom_range(0, 4);
		repeat (n) begin
			// steer samples around the targets so axes can settle exactly
			az = ($urandom_range(0, 1)) ? 9'($urandom) : 9'(az_goal + $urandom_range(0, 2));
			el = ($urandom_range(0, 1)) ? 9'($urandom) : 9'(el_goal + $urandom_range(0, 2));
			send_tick(az, el);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	dir_row_t dir_tab[$];

	function automatic void row(logic f, logic [7:0] b, logic [8:0] az, logic [8:0] el,
			string text);
		dir_row_t r;
		r.f = f; r.b = b; r.az = az; r.el = el; r.text = text;
		dir_tab.push_back(r);
	endfunction

	initial begin
		int unsigned quota;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = 1'b0;
		rx_byte = 8'h00;
		azimuth_sample = 9'h000;
		elevation_sample = 9'h000;
		cfg_valid = 1'b0;
		cfg_index = REG_AZ_LIMIT;
		cfg_data = 9'h000;
		out_ready = 1'b0;
		errors = 0;
		items_in = 0;
		cycles = 0;
		burst_left = 0;
		for (int k = 0; k < 8; k++) line_chars[k] = 8'h00;
		for (int k = 0; k < RING_DEPTH; k++) begin
			az_ring[k] = '0;
			el_ring[k] = '0;
		end
		line_len = 0; ring_idx = 0; az_total = 0; el_total = 0;
		az_goal = 0; el_goal = 0; az_moving = 0; el_moving = 0;
		last_el = '0; az_motor = DRV_OFF; el_motor = DRV_OFF;
		az_lim = AZ_LIMIT_RST; el_lim = EL_LIMIT_RST;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reports after reset, several commands, extremes, errors
		row(0, CMD_REPORT, 0, 0, "");
		row(0, CMD_BOTH, 0, 0, "");
		row(0, CH_CR, 0, 0, "+0000+0000\r\n");
		row(0, CMD_ELEV, 0, 0, "");
		row(0, CH_CR, 0, 0, "+0000\r\n");
		row(0, "X", 0, 0, "");
		row(0, CH_CR, 0, 0, "? >");
		row(0, CMD_STOP, 0, 0, "");
		row(0, CH_CR, 0, 0, "\r\n");
		row(1, 8'hff, 9'h1ff, 9'h1ff, "");
		row(0, CMD_ELEV, 0, 0, "");
		row(0, CH_CR, 0, 0, "+0511\r\n");
		row(1, 8'h00, 9'h000, 9'h000, "");
		row(0, CMD_MOVE, 0, 0, "");
		row(0, "9", 0, 0, "");
		row(0, "9", 0, 0, "");
		row(0, "9", 0, 0, "");
		row(0, CH_CR, 0, 0, "? >");
		row(0, CH_CR, 0, 0, "");           // empty line: no reply
		row(0, CMD_RIGHT, 0, 0, "");
		row(0, CH_CR, 0, 0, "\r\n");
		row(0, CMD_UP, 0, 0, "");
		row(0, CH_CR, 0, 0, "\r\n");
		row(1, 8'h5a, 9'h0aa, 9'h155, "");
		foreach (dir_tab[i])
			offer(dir_tab[i].f, dir_tab[i].b, dir_tab[i].az, dir_tab[i].el, dir_tab[i].text);
		drain();

		// random phases over several limit settings, extremes among them
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin write_reg(REG_AZ_LIMIT, 9'd360); write_reg(REG_EL_LIMIT, 9'd180); end
				1: begin write_reg(REG_AZ_LIMIT, 9'd511); write_reg(REG_EL_LIMIT, 9'd511); end
				2: begin write_reg(REG_AZ_LIMIT, 9'd0); write_reg(REG_EL_LIMIT, 9'd0); end
				default: begin
					write_reg(REG_EL_LIMIT, 9'($urandom));
					write_reg(REG_AZ_LIMIT, 9'($urandom));
				end
			endcase
			quota = items_in + 100;
			while (items_in < quota) begin
				send_ticks();
				send_command();
			end
			drain();
		end

		if (errors == 0) begin
			$display("[rotator_command_position_control] OK");
		end else begin
			$display("[rotator_command_position_control] ERROR");
		end
		$finish;
	end
endmodule
